FILE: hdl/pid_controller_antiwindup_assert.svh
// Assertion macros for the PID controller block
`ifndef PID_CONTROLLER_ANTIWINDUP_ASSERT_SVH
`define PID_CONTROLLER_ANTIWINDUP_ASSERT_SVH
`ifndef SYNTHESIS
// consequent checked in the same cycle
`define PIDAW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pidaw check failed");
// consequent checked in the cycle after the antecedent
`define PIDAW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pidaw check failed");
`else
`define PIDAW_ASSERT_NOW(label, ante, cons)
`define PIDAW_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: hdl/pidaw_pkg.sv
// Shared constants, types and codes for the PID controller block
`default_nettype none

package pidaw_pkg;

  // field widths
  localparam int FIELD_W    = 32;
  localparam int PERIOD_W   = 31;
  localparam int ERR_W      = 33;
  localparam int CFG_ADDR_W = 4;

  // top level parameter defaults
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // serial unit widths
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 33;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int DIV_N_W = 63;

  // derivative quotient limit, 2^48
  localparam logic [DIV_N_W-1:0] D_LIM = 63'h1_0000_0000_0000;

  // error difference limit, 2^32 - 1
  localparam logic [ERR_W-1:0] DIF_LIM = 33'h0_FFFF_FFFF;

  // item modes
  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  // register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PROP_GAIN     = 4'd0,
    REG_INTEG_GAIN    = 4'd1,
    REG_DERIV_GAIN    = 4'd2,
    REG_SAMPLE_PERIOD = 4'd3,
    REG_INTEG_UPPER   = 4'd4,
    REG_INTEG_LOWER   = 4'd5,
    REG_OUT_UPPER     = 4'd6,
    REG_OUT_LOWER     = 4'd7
  } reg_idx_t;

  // register reset values
  localparam logic signed [FIELD_W-1:0] PROP_GAIN_RST  = 32'sh0001_0000;
  localparam logic signed [FIELD_W-1:0] INTEG_GAIN_RST = 32'sh0000_0000;
  localparam logic signed [FIELD_W-1:0] DERIV_GAIN_RST = 32'sh0000_0000;
  localparam logic [PERIOD_W-1:0]       PERIOD_RST     = 31'd655;
  localparam logic signed [FIELD_W-1:0] UPPER_RST      = 32'sh7FFF_FFFF;
  localparam logic signed [FIELD_W-1:0] LOWER_RST      = 32'sh8000_0000;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIF,
    ST_MUL1,
    ST_PREP,
    ST_KICK,
    ST_MUL2,
    ST_INTEG,
    ST_ICLAMP,
    ST_SUM,
    ST_SAT,
    ST_OCLAMP,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: hdl/pidaw_if.sv
// Handshake channels of the PID controller: command, result and register write
`default_nettype none

interface pidaw_cmd_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   mode;
  logic signed [pidaw_pkg::FIELD_W-1:0]   target;
  logic signed [pidaw_pkg::FIELD_W-1:0]   measured;
  modport source (output valid, mode, target, measured, input ready);
  modport sink (input valid, mode, target, measured, output ready);
endinterface

interface pidaw_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [pidaw_pkg::FIELD_W-1:0]   drive;
  modport source (output valid, drive, input ready);
  modport sink (input valid, drive, output ready);
endinterface

interface pidaw_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [pidaw_pkg::CFG_ADDR_W-1:0]       index;
  logic [pidaw_pkg::FIELD_W-1:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/pid_controller_antiwindup.sv
// PID controller with integral clamp, signed fixed point, serial arithmetic.
// Update item: error difference, three 33-step shift-add multipliers in parallel, scaling,
// then the 63-step restoring divider beside a ki * sample period multiply, integral clamp,
// sum, saturation and output clamp. One item at a time; a clear item skips to the result.
// Synchronous reset loads the register defaults and zeroes integral and previous error.
`default_nettype none
`include "pid_controller_antiwindup_assert.svh"

module pid_controller_antiwindup #(
  parameter int DATA_WIDTH = pidaw_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = pidaw_pkg::FRAC_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  pidaw_cmd_if.sink   cmd,
  pidaw_rsp_if.source result,
  pidaw_cfg_if.sink   cfg
);

  localparam int FIELD_W  = pidaw_pkg::FIELD_W;
  localparam int PERIOD_W = pidaw_pkg::PERIOD_W;
  localparam int ERR_W    = pidaw_pkg::ERR_W;
  localparam int MUL_A_W  = pidaw_pkg::MUL_A_W;
  localparam int MUL_B_W  = pidaw_pkg::MUL_B_W;
  localparam int PROD_W   = pidaw_pkg::PROD_W;
  localparam int SUM_W    = pidaw_pkg::SUM_W;
  localparam int DIV_N_W  = pidaw_pkg::DIV_N_W;

  localparam logic signed [SUM_W-1:0] S_MAX = (SUM_W'(1) <<< (DATA_WIDTH - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] S_MIN = ~S_MAX;

  pidaw_pkg::state_t state;
  pidaw_pkg::state_t state_next;

  // registers
  logic signed [FIELD_W-1:0] prop_gain;
  logic signed [FIELD_W-1:0] integ_gain;
  logic signed [FIELD_W-1:0] deriv_gain;
  logic [PERIOD_W-1:0]       sample_period;
  logic signed [FIELD_W-1:0] integ_upper;
  logic signed [FIELD_W-1:0] integ_lower;
  logic signed [FIELD_W-1:0] out_upper;
  logic signed [FIELD_W-1:0] out_lower;

  // loop state
  logic signed [FIELD_W-1:0] integ_acc;
  logic signed [ERR_W-1:0]   last_error;

  // working registers
  logic                      clr;
  logic signed [ERR_W-1:0]   err;
  logic signed [SUM_W-1:0]   p_term;
  logic signed [FIELD_W-1:0] ki;
  logic                      d_neg;
  logic [DIV_N_W-1:0]        d_mag;
  logic signed [SUM_W-1:0]   isum;
  logic signed [SUM_W-1:0]   d_term;
  logic signed [FIELD_W-1:0] integ_new;
  logic signed [SUM_W-1:0]   sum;
  logic signed [FIELD_W-1:0] drive_res;
  logic                      out_valid;
  logic signed [FIELD_W-1:0] drive_reg;

  // sequencer outputs
  logic load;
  logic start_first;
  logic start_second;

  // serial units
  logic [MUL_A_W-1:0] mul_i_a;
  logic [MUL_B_W-1:0] mul_i_b;
  logic [PROD_W-1:0]  prod_p;
  logic [PROD_W-1:0]  prod_i;
  logic [PROD_W-1:0]  prod_d;
  logic [DIV_N_W-1:0] quo;
  logic               mul_p_busy;
  logic               mul_i_busy;
  logic               mul_d_busy;
  logic               div_busy;

  // datapath nets
  logic signed [ERR_W:0]     dif_full;
  logic signed [ERR_W-1:0]   dif;
  logic signed [PROD_W-1:0]  p_shift;
  logic signed [PROD_W-1:0]  k_shift;
  logic [PROD_W-FIELD_W:0]   k_top;
  logic signed [FIELD_W-1:0] ki_sat;
  logic [PROD_W-1:0]         d_abs;
  logic [DIV_N_W-1:0]        q_lim;
  logic [SUM_W-1:0]          q_ext;
  logic signed [SUM_W-1:0]   d_val;
  logic signed [SUM_W-1:0]   iu_ext;
  logic signed [SUM_W-1:0]   il_ext;
  logic signed [SUM_W-1:0]   i_clamp;
  logic [SUM_W-DATA_WIDTH:0] s_top;
  logic signed [SUM_W-1:0]   sum_sat;
  logic signed [SUM_W-1:0]   ou_ext;
  logic signed [SUM_W-1:0]   ol_ext;
  logic signed [SUM_W-1:0]   o_clamp;

  // register writes, always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain     <= pidaw_pkg::PROP_GAIN_RST;
      integ_gain    <= pidaw_pkg::INTEG_GAIN_RST;
      deriv_gain    <= pidaw_pkg::DERIV_GAIN_RST;
      sample_period <= pidaw_pkg::PERIOD_RST;
      integ_upper   <= pidaw_pkg::UPPER_RST;
      integ_lower   <= pidaw_pkg::LOWER_RST;
      out_upper     <= pidaw_pkg::UPPER_RST;
      out_lower     <= pidaw_pkg::LOWER_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        pidaw_pkg::REG_PROP_GAIN:     prop_gain     <= cfg.data;
        pidaw_pkg::REG_INTEG_GAIN:    integ_gain    <= cfg.data;
        pidaw_pkg::REG_DERIV_GAIN:    deriv_gain    <= cfg.data;
        pidaw_pkg::REG_SAMPLE_PERIOD: sample_period <= cfg.data[PERIOD_W-1:0];
        pidaw_pkg::REG_INTEG_UPPER:   integ_upper   <= cfg.data;
        pidaw_pkg::REG_INTEG_LOWER:   integ_lower   <= cfg.data;
        pidaw_pkg::REG_OUT_UPPER:     out_upper     <= cfg.data;
        pidaw_pkg::REG_OUT_LOWER:     out_lower     <= cfg.data;
        default: ;
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pidaw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and controls
  always_comb begin
    state_next = state;
    load       = 1'b0;
    case (state)
      pidaw_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          state_next = (cmd.mode == pidaw_pkg::MODE_CLEAR) ? pidaw_pkg::ST_DONE
                                                           : pidaw_pkg::ST_DIF;
        end
      end
      pidaw_pkg::ST_DIF:    state_next = pidaw_pkg::ST_MUL1;
      pidaw_pkg::ST_MUL1: begin
        if (!mul_p_busy && !mul_i_busy && !mul_d_busy) begin
          state_next = pidaw_pkg::ST_PREP;
        end
      end
      pidaw_pkg::ST_PREP:   state_next = pidaw_pkg::ST_KICK;
      pidaw_pkg::ST_KICK:   state_next = pidaw_pkg::ST_MUL2;
      pidaw_pkg::ST_MUL2: begin
        if (!mul_i_busy && !div_busy) begin
          state_next = pidaw_pkg::ST_INTEG;
        end
      end
      pidaw_pkg::ST_INTEG:  state_next = pidaw_pkg::ST_ICLAMP;
      pidaw_pkg::ST_ICLAMP: state_next = pidaw_pkg::ST_SUM;
      pidaw_pkg::ST_SUM:    state_next = pidaw_pkg::ST_SAT;
      pidaw_pkg::ST_SAT:    state_next = pidaw_pkg::ST_OCLAMP;
      pidaw_pkg::ST_OCLAMP: state_next = pidaw_pkg::ST_DONE;
      pidaw_pkg::ST_DONE: begin
        if (!out_valid || result.ready) begin
          load       = 1'b1;
          state_next = pidaw_pkg::ST_IDLE;
        end
      end
      default: state_next = pidaw_pkg::ST_IDLE;
    endcase
  end

  assign cmd.ready    = (state == pidaw_pkg::ST_IDLE);
  assign start_first  = (state == pidaw_pkg::ST_DIF);
  assign start_second = (state == pidaw_pkg::ST_KICK);

  // error difference, limited to +-(2^32 - 1)
  always_comb begin
    dif_full = {err[ERR_W-1], err} - {last_error[ERR_W-1], last_error};
    dif      = dif_full[ERR_W-1:0];
    if (!dif_full[ERR_W] && dif_full[ERR_W-1]) begin
      dif = pidaw_pkg::DIF_LIM;
    end else if (dif_full[ERR_W] && (!dif_full[ERR_W-1] || dif_full[ERR_W-2:0] == '0)) begin
      dif = -pidaw_pkg::DIF_LIM;
    end
  end

  // the integral multiplier is reused for ki * sample period
  assign mul_i_a = start_second ? ki : integ_gain;
  assign mul_i_b = start_second ? MUL_B_W'(sample_period) : err;

  pidaw_mul #(.A_W(MUL_A_W), .B_W(MUL_B_W)) u_mul_p (
    .clk(clk), .rst(rst), .start(start_first),
    .a(prop_gain), .b(err), .busy(mul_p_busy), .prod(prod_p)
  );

  pidaw_mul #(.A_W(MUL_A_W), .B_W(MUL_B_W)) u_mul_i (
    .clk(clk), .rst(rst), .start(start_first || start_second),
    .a(mul_i_a), .b(mul_i_b), .busy(mul_i_busy), .prod(prod_i)
  );

  pidaw_mul #(.A_W(MUL_A_W), .B_W(MUL_B_W)) u_mul_d (
    .clk(clk), .rst(rst), .start(start_first),
    .a(deriv_gain), .b(dif), .busy(mul_d_busy), .prod(prod_d)
  );

  pidaw_div #(.N_W(DIV_N_W), .D_W(PERIOD_W)) u_div (
    .clk(clk), .rst(rst), .start(start_second),
    .num(d_mag), .den(sample_period), .busy(div_busy), .quo(quo)
  );

  // products scaled back, ki limited to 32 bits, magnitude for the divider
  always_comb begin
    p_shift = $signed(prod_p) >>> FRAC_BITS;
    k_shift = $signed(prod_i) >>> FRAC_BITS;
    k_top   = k_shift[PROD_W-1:FIELD_W-1];
    ki_sat  = k_shift[FIELD_W-1:0];
    if (!((&k_top) || !(|k_top))) begin
      ki_sat = k_top[PROD_W-FIELD_W] ? pidaw_pkg::LOWER_RST : pidaw_pkg::UPPER_RST;
    end
    d_abs = prod_d[PROD_W-1] ? (~prod_d + 1'b1) : prod_d;
  end

  // derivative term: quotient limited to 2^48, sign restored, zero period gives zero
  always_comb begin
    q_lim = (quo > pidaw_pkg::D_LIM) ? pidaw_pkg::D_LIM : quo;
    q_ext = {{(SUM_W-DIV_N_W){1'b0}}, q_lim};
    if (sample_period == '0) begin
      d_val = '0;
    end else begin
      d_val = d_neg ? -q_ext : q_ext;
    end
  end

  // integral clamp, lower bound applied last
  always_comb begin
    iu_ext  = {{(SUM_W-FIELD_W){integ_upper[FIELD_W-1]}}, integ_upper};
    il_ext  = {{(SUM_W-FIELD_W){integ_lower[FIELD_W-1]}}, integ_lower};
    i_clamp = isum;
    if (i_clamp > iu_ext) begin
      i_clamp = iu_ext;
    end
    if (i_clamp < il_ext) begin
      i_clamp = il_ext;
    end
  end

  // saturation to the data width
  always_comb begin
    s_top   = sum[SUM_W-1:DATA_WIDTH-1];
    sum_sat = sum;
    if (!((&s_top) || !(|s_top))) begin
      sum_sat = sum[SUM_W-1] ? S_MIN : S_MAX;
    end
  end

  // output clamp, lower bound applied last
  always_comb begin
    ou_ext  = {{(SUM_W-FIELD_W){out_upper[FIELD_W-1]}}, out_upper};
    ol_ext  = {{(SUM_W-FIELD_W){out_lower[FIELD_W-1]}}, out_lower};
    o_clamp = sum;
    if (o_clamp > ou_ext) begin
      o_clamp = ou_ext;
    end
    if (o_clamp < ol_ext) begin
      o_clamp = ol_ext;
    end
  end

  // working registers, one step per state
  always_ff @(posedge clk) begin
    case (state)
      pidaw_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          clr <= (cmd.mode == pidaw_pkg::MODE_CLEAR);
          err <= {cmd.target[FIELD_W-1], cmd.target}
               - {cmd.measured[FIELD_W-1], cmd.measured};
        end
      end
      pidaw_pkg::ST_PREP: begin
        p_term <= {{(SUM_W-PROD_W){p_shift[PROD_W-1]}}, p_shift};
        ki     <= ki_sat;
        d_neg  <= prod_d[PROD_W-1];
        d_mag  <= d_abs[DIV_N_W-1:0];
      end
      pidaw_pkg::ST_INTEG: begin
        isum   <= {{(SUM_W-FIELD_W){integ_acc[FIELD_W-1]}}, integ_acc}
                + {{(SUM_W-PROD_W){k_shift[PROD_W-1]}}, k_shift};
        d_term <= d_val;
      end
      pidaw_pkg::ST_ICLAMP: begin
        integ_new <= i_clamp[FIELD_W-1:0];
        sum       <= p_term + d_term;
      end
      pidaw_pkg::ST_SUM: begin
        sum <= sum + {{(SUM_W-FIELD_W){integ_new[FIELD_W-1]}}, integ_new};
      end
      pidaw_pkg::ST_SAT: begin
        sum <= sum_sat;
      end
      pidaw_pkg::ST_OCLAMP: begin
        drive_res <= o_clamp[FIELD_W-1:0];
      end
      default: ;
    endcase
  end

  // loop state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      integ_acc  <= '0;
      last_error <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (load) begin
        out_valid  <= 1'b1;
        integ_acc  <= clr ? '0 : integ_new;
        last_error <= clr ? '0 : err;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      drive_reg <= clr ? '0 : drive_res;
    end
  end

  assign result.valid = out_valid;
  assign result.drive = drive_reg;

  // checks
  `PIDAW_ASSERT_NEXT(a_accept_from_idle, cmd.valid && cmd.ready, state == pidaw_pkg::ST_DIF || state == pidaw_pkg::ST_DONE)
  `PIDAW_ASSERT_NOW(a_units_finished, state == pidaw_pkg::ST_INTEG, !mul_i_busy && !div_busy)
  `PIDAW_ASSERT_NEXT(a_clear_gives_zero, load && clr, result.valid && result.drive == '0)
  `PIDAW_ASSERT_NEXT(a_drive_in_bounds, load && !clr && out_lower <= out_upper, result.drive <= out_upper && result.drive >= out_lower)

endmodule

`default_nettype wire

FILE: hdl/pidaw_mul.sv
// Shift-add signed multiplier, one multiplier bit per cycle
`default_nettype none

module pidaw_mul #(
  parameter int A_W = pidaw_pkg::MUL_A_W,
  parameter int B_W = pidaw_pkg::MUL_B_W
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [A_W-1:0]     a,
  input  wire logic [B_W-1:0]     b,
  output logic                    busy,
  output logic [A_W+B_W-1:0]      prod
);

  localparam int CNT_W = $clog2(B_W);

  logic [A_W-1:0]       mcand;
  logic [CNT_W-1:0]     cnt;
  logic [A_W+B_W-1:0]   acc;
  logic [A_W:0]         hi;
  logic [A_W:0]         addend;
  logic [A_W:0]         hsum;
  logic                 last;

  // partial sum: add the multiplicand, subtract it on the sign bit
  always_comb begin
    last   = (cnt == CNT_W'(B_W - 1));
    hi     = {acc[A_W+B_W-1], acc[A_W+B_W-1:B_W]};
    addend = '0;
    if (acc[0]) begin
      addend = last ? -{mcand[A_W-1], mcand} : {mcand[A_W-1], mcand};
    end
    hsum = hi + addend;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (last) begin
        busy <= 1'b0;
      end
    end
  end

  // product shifts right one bit a step, multiplier bits leave at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= {{A_W{1'b0}}, b};
      mcand <= a;
    end else if (busy) begin
      acc <= {hsum, acc[B_W-1:1]};
    end
  end

  assign prod = acc;

endmodule

`default_nettype wire

FILE: hdl/pidaw_div.sv
// Restoring unsigned divider, one quotient bit per cycle
`default_nettype none

module pidaw_div #(
  parameter int N_W = pidaw_pkg::DIV_N_W,
  parameter int D_W = pidaw_pkg::PERIOD_W
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [N_W-1:0]   num,
  input  wire logic [D_W-1:0]   den,
  output logic                  busy,
  output logic [N_W-1:0]        quo
);

  localparam int CNT_W = $clog2(N_W);

  logic [N_W-1:0]   q;
  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   dsr;
  logic [CNT_W-1:0] cnt;
  logic [D_W:0]     r_sh;
  logic [D_W+1:0]   diff;
  logic             fit;

  // trial subtract of the shifted remainder
  always_comb begin
    r_sh = {rem, q[N_W-1]};
    diff = {1'b0, r_sh} - {2'b00, dsr};
    fit  = !diff[D_W+1];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(N_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // dividend shifts out at the top, quotient bits in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
      dsr <= den;
    end else if (busy) begin
      rem <= fit ? diff[D_W-1:0] : r_sh[D_W-1:0];
      q   <= {q[N_W-2:0], fit};
    end
  end

  assign quo = q;

endmodule

`default_nettype wire
